/* design/hrp_pkg.sv */
`default_nettype none

package hrp_pkg;

	// field limits
	localparam int unsigned MAX_RESOURCE = 2048;
	localparam int unsigned MAX_VERSION = 1024;
	localparam logic [4:0] NAME_SAT = 5'd18;
	localparam logic [4:0] NAME_LEN = 5'd10;

	// byte codes
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_NUL = 8'h00;

	// version form bits
	localparam int unsigned VF_LEAD = 0;
	localparam int unsigned VF_DOT = 1;
	localparam int unsigned VF_TAIL = 2;
	localparam int unsigned VF_BAD = 3;

	typedef enum logic [2:0] {
		KIND_RESOURCE = 3'd0,
		KIND_VERSION = 3'd1,
		KIND_COMPLETE = 3'd2,
		KIND_BAD_REQUEST = 3'd3,
		KIND_TOO_LONG = 3'd4
	} hrp_kind_t;

	typedef enum logic [2:0] {
		PH_METHOD = 3'd0,
		PH_RESOURCE = 3'd1,
		PH_PREFIX = 3'd2,
		PH_VERSION = 3'd3,
		PH_HEADERS = 3'd4
	} hrp_phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic stream_end;
	} hrp_item_t;

	typedef struct packed {
		hrp_kind_t kind;
		logic [7:0] data_byte;
		logic close_requested;
		logic [11:0] resource_length;
	} hrp_result_t;

	typedef struct packed {
		hrp_phase_t phase;
		logic [2:0] match_index;
		logic [11:0] resource_count;
		logic [10:0] version_count;
		logic [3:0] version_form;
		logic line_started;
		logic [4:0] name_position;
		logic separator_seen;
		logic name_matches;
		logic close_flag;
	} hrp_state_t;

	localparam hrp_state_t STATE_RESET = '{
		phase: PH_METHOD,
		match_index: 3'd0,
		resource_count: 12'd0,
		version_count: 11'd0,
		version_form: 4'd0,
		line_started: 1'b0,
		name_position: 5'd0,
		separator_seen: 1'b0,
		name_matches: 1'b1,
		close_flag: 1'b0
	};

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic [7:0] method_char(input logic [2:0] idx);
		case (idx)
			3'd0: return "G";
			3'd1: return "E";
			3'd2: return "T";
			default: return CH_NUL;
		endcase
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		case (idx)
			3'd0: return "H";
			3'd1: return "T";
			3'd2: return "T";
			3'd3: return "P";
			3'd4: return "/";
			default: return CH_NUL;
		endcase
	endfunction

	function automatic logic [7:0] name_char(input logic [4:0] idx);
		case (idx)
			5'd0: return "c";
			5'd1: return "o";
			5'd2: return "n";
			5'd3: return "n";
			5'd4: return "e";
			5'd5: return "c";
			5'd6: return "t";
			5'd7: return "i";
			5'd8: return "o";
			5'd9: return "n";
			default: return CH_NUL;
		endcase
	endfunction

	function automatic logic [7:0] value_char(input logic [2:0] idx);
		case (idx)
			3'd0: return ":";
			3'd1: return " ";
			3'd2: return "c";
			3'd3: return "l";
			3'd4: return "o";
			3'd5: return "s";
			3'd6: return "e";
			default: return CH_NUL;
		endcase
	endfunction

endpackage

`default_nettype wire

/* design/hrp_step.sv */
`default_nettype none

module hrp_step
	import hrp_pkg::*;
(
	input  wire hrp_state_t  cur,
	input  wire hrp_item_t   item,
	output hrp_state_t  nxt,
	output logic        emit,
	output hrp_result_t res
);

	// next state and result for one byte
	always_comb begin
		logic [7:0] c;
		logic nl;
		logic verdict;
		hrp_kind_t verdict_kind;
		logic skip_rest;
		logic ok;
		logic [4:0] vpos;

		c = item.rx_byte;
		nl = (c == CH_LF);
		verdict = 1'b0;
		verdict_kind = KIND_BAD_REQUEST;
		skip_rest = 1'b0;
		ok = 1'b0;
		vpos = cur.name_position - NAME_LEN;
		nxt = cur;
		emit = 1'b0;
		res.kind = KIND_RESOURCE;
		res.data_byte = 8'd0;
		res.close_requested = 1'b0;
		res.resource_length = 12'd0;

		if (item.stream_end) begin
			verdict = 1'b1;
		end else if (c != CH_CR) begin
			case (cur.phase)
				PH_METHOD: begin
					if (cur.match_index > 3'd2 || c != method_char(cur.match_index)) begin
						verdict = 1'b1;
					end else if (cur.match_index == 3'd2) begin
						nxt.phase = PH_RESOURCE;
						nxt.match_index = 3'd0;
					end else begin
						nxt.match_index = cur.match_index + 3'd1;
					end
				end
				PH_RESOURCE: begin
					if (is_blank(c)) begin
						if (cur.resource_count != 12'd0) begin
							nxt.phase = PH_PREFIX;
							nxt.match_index = 3'd0;
						end
					end else if (nl) begin
						verdict = 1'b1;
					end else if (cur.resource_count > 12'(MAX_RESOURCE)) begin
						verdict = 1'b1;
						verdict_kind = KIND_TOO_LONG;
					end else begin
						nxt.resource_count = cur.resource_count + 12'd1;
						emit = 1'b1;
						res.kind = KIND_RESOURCE;
						res.data_byte = c;
					end
				end
				PH_PREFIX: begin
					if (cur.match_index == 3'd0 && is_blank(c)) begin
						nxt = cur;
					end else if (cur.match_index > 3'd4 ||
						c != prefix_char(cur.match_index)) begin
						verdict = 1'b1;
					end else if (cur.match_index == 3'd4) begin
						nxt.phase = PH_VERSION;
						nxt.match_index = 3'd0;
					end else begin
						nxt.match_index = cur.match_index + 3'd1;
					end
				end
				PH_VERSION: begin
					if (nl) begin
						if (cur.version_form[VF_BAD] || !cur.version_form[VF_DOT] ||
							!cur.version_form[VF_LEAD] || !cur.version_form[VF_TAIL]) begin
							verdict = 1'b1;
						end else begin
							nxt.phase = PH_HEADERS;
						end
					end else if (cur.version_count >= 11'(MAX_VERSION)) begin
						verdict = 1'b1;
						verdict_kind = KIND_TOO_LONG;
					end else begin
						nxt.version_count = cur.version_count + 11'd1;
						if (c >= CH_ZERO && c <= CH_NINE) begin
							if (cur.version_form[VF_DOT]) begin
								nxt.version_form[VF_TAIL] = 1'b1;
							end else begin
								nxt.version_form[VF_LEAD] = 1'b1;
							end
						end else if (c == CH_DOT && !cur.version_form[VF_DOT]) begin
							nxt.version_form[VF_DOT] = 1'b1;
						end else begin
							nxt.version_form[VF_BAD] = 1'b1;
						end
						emit = 1'b1;
						res.kind = KIND_VERSION;
						res.data_byte = c;
					end
				end
				PH_HEADERS: begin
					// blank line ends the request
					if (!cur.line_started && nl) begin
						verdict = 1'b1;
						verdict_kind = KIND_COMPLETE;
					end else begin
						// new line: a leading blank folds onto the previous line
						if (!cur.line_started) begin
							if (is_blank(c)) begin
								nxt.line_started = 1'b1;
								skip_rest = 1'b1;
							end else begin
								nxt.separator_seen = 1'b0;
								nxt.name_position = 5'd0;
							end
						end
						if (!skip_rest) begin
							vpos = nxt.name_position - NAME_LEN;
							// separator
							if (c == CH_COLON) begin
								nxt.separator_seen = 1'b1;
								if (nxt.name_matches && nxt.name_position == NAME_LEN) begin
									nxt.close_flag = 1'b1;
								end else begin
									nxt.name_matches = 1'b0;
								end
							end
							// name or value compare
							if (!nxt.separator_seen) begin
								if (nxt.name_position > 5'd9 ||
									to_lower(c) != name_char(nxt.name_position)) begin
									nxt.name_matches = 1'b0;
								end
							end else if (nxt.name_matches) begin
								if (nxt.name_position < NAME_LEN) begin
									ok = 1'b0;
								end else if (vpos > 5'd6) begin
									ok = (vpos == 5'd7) && (c == CH_NUL);
								end else begin
									ok = (c == value_char(vpos[2:0]));
								end
								if (!ok && !(nxt.name_position == 5'd17 && nl)) begin
									nxt.close_flag = 1'b0;
								end
							end
							// line end or position advance
							if (nl) begin
								nxt.line_started = 1'b0;
								nxt.name_matches = 1'b1;
							end else begin
								nxt.line_started = 1'b1;
								if (nxt.name_position < NAME_SAT) begin
									nxt.name_position = nxt.name_position + 5'd1;
								end
							end
						end
					end
				end
				default: begin
					nxt = STATE_RESET;
				end
			endcase
		end

		// every verdict restarts the parser
		if (verdict) begin
			emit = 1'b1;
			res.kind = verdict_kind;
			res.data_byte = 8'd0;
			if (verdict_kind == KIND_COMPLETE) begin
				res.close_requested = cur.close_flag;
				res.resource_length = cur.resource_count;
			end
			nxt = STATE_RESET;
		end
	end

endmodule

`default_nettype wire

/* design/http_request_header_parser.sv */
`default_nettype none

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+--------------------------------
// item     | in        | item_valid / item_stall   | rx_byte, stream_end
// result   | out       | result_valid / result_stall | kind, data_byte, close_requested,
//          |           |                           | resource_length
//
// one byte per cycle sustained while result_stall stays low; a byte's result passes
// through the input register, then parser logic into the result register
// arst_n low returns the parser to method matching with both stages empty
// a waiting result does not block the input register; the input stalls only while
// its byte cannot move into an occupied, stalled result register

module http_request_header_parser
	import hrp_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         item_valid,
	output logic        item_stall,
	input  wire hrp_item_t item,
	output logic        result_valid,
	input  wire         result_stall,
	output hrp_result_t result
);

	hrp_item_t item_s1;
	logic valid_s1;
	hrp_state_t state_q;
	hrp_state_t state_nxt;
	logic step_emit;
	hrp_result_t step_res;
	hrp_result_t result_q;
	logic result_valid_q;
	logic advance;

	// byte moves from the input register into the parser
	assign advance = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	hrp_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.emit (step_emit),
		.res  (step_res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= step_emit;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_emit) begin
			result_q <= step_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

`default_nettype wire
